// ===== src/tdns_pkg.sv =====
// ---------------------------------------------------------------------------
// tdns_pkg: shared types and constants for the note sequencer
// Command codes, configuration register indexes, song entry layout and the
// semitone frequency table.
// ---------------------------------------------------------------------------
`default_nettype none

package tdns_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_PLAY   = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5
  } cmd_t;

  typedef enum logic {
    REG_LOOP_ENABLE  = 1'b0,
    REG_TICK_STEP_MS = 1'b1
  } cfg_reg_t;

  localparam int unsigned NOTE_W  = 8;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned FREQ_W  = 12;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned ELAPS_W = 17;
  localparam int unsigned POS_OUT_W = 9;

  localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

  typedef struct packed {
    logic [DUR_W-1:0]         duration;
    logic signed [NOTE_W-1:0] note;
  } song_entry_t;

  localparam int unsigned HZ_ENTRIES = 100;

  localparam logic [FREQ_W-1:0] SEMITONE_HZ [HZ_ENTRIES] = '{
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd15,   12'd16,   12'd17,   12'd18,
    12'd19,   12'd21,   12'd22,   12'd23,   12'd25,
    12'd26,   12'd28,   12'd29,   12'd31,   12'd33,
    12'd35,   12'd37,   12'd39,   12'd41,   12'd44,
    12'd46,   12'd49,   12'd52,   12'd55,   12'd58,
    12'd62,   12'd65,   12'd69,   12'd73,   12'd78,
    12'd82,   12'd87,   12'd92,   12'd98,   12'd104,
    12'd110,  12'd117,  12'd123,  12'd131,  12'd139,
    12'd147,  12'd156,  12'd165,  12'd175,  12'd185,
    12'd196,  12'd208,  12'd220,  12'd233,  12'd247,
    12'd262,  12'd277,  12'd294,  12'd311,  12'd330,
    12'd349,  12'd370,  12'd392,  12'd415,  12'd440,
    12'd466,  12'd494,  12'd523,  12'd554,  12'd587,
    12'd622,  12'd659,  12'd698,  12'd740,  12'd784,
    12'd831,  12'd880,  12'd932,  12'd988,  12'd1047,
    12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
    12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865,
    12'd1976, 12'd2093, 12'd2218, 12'd2349, 12'd2489
  };

  // Notes past the end of the table are silent.
  function automatic logic [FREQ_W-1:0] note_hz(input logic [6:0] n);
    logic [FREQ_W-1:0] hz;
    hz = '0;
    if (n < 7'(HZ_ENTRIES)) begin
      hz = SEMITONE_HZ[n];
    end
    return hz;
  endfunction

endpackage

`default_nettype wire

// ===== src/tdns_song_mem.sv =====
// ---------------------------------------------------------------------------
// tdns_song_mem: song entry store
// One write port, two registered read ports (current and next position).
// ---------------------------------------------------------------------------
`default_nettype none

module tdns_song_mem #(
  parameter int unsigned SONG_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(SONG_DEPTH)-1:0]       wr_addr,
  input  wire tdns_pkg::song_entry_t               wr_data,
  input  wire logic                                rd_en,
  input  wire logic [$clog2(SONG_DEPTH)-1:0]       rd_addr_cur,
  input  wire logic [$clog2(SONG_DEPTH)-1:0]       rd_addr_nxt,
  output tdns_pkg::song_entry_t                    rd_cur,
  output tdns_pkg::song_entry_t                    rd_nxt
);

  tdns_pkg::song_entry_t mem [SONG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cur <= mem[rd_addr_cur];
      rd_nxt <= mem[rd_addr_nxt];
    end
  end

endmodule

`default_nettype wire

// ===== src/tick_driven_note_sequencer.sv =====
// ---------------------------------------------------------------------------
// tick_driven_note_sequencer: memory based melody player
// Plays a song of note/duration entries held in an on-chip memory.
// ---------------------------------------------------------------------------
// Usage
//   s_* : command items. s_tuser carries the command (tick, load entry, play,
//         stop, pause, resume); s_tdata carries the entry fields for loads.
//   m_* : one result item per command, showing tone, position and play state
//         after that command.
//   cfg_* : register writes (loop enable, tick step); always ready. They are
//         to be written only while the block is idle; this is not enforced.
// Flow
//   An item is taken in ST_IDLE; its result is registered in ST_EXEC once the
//   output register is free, and no new item is taken before then. A tick
//   reads the entry at the current position and the next note together
//   from the song memory's two read ports; the state updates with the result.
// Reset
//   Synchronous, active high. Position, elapsed time, last note, play and
//   tone state clear, tick step returns to 10 ms. The song memory is not
//   cleared; entries must be loaded before they are played.
// Back-pressure
//   A result waits in the output register while the next item is taken; that
//   item then holds until the result is taken, and the input stalls meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module tick_driven_note_sequencer #(
  parameter int unsigned SONG_DEPTH      = 256,
  parameter int unsigned NOTE_TABLE_SIZE = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [7:0] entry_index, [15:8] entry_note,
                                      // [31:16] entry_duration
  input  wire logic [2:0]  s_tuser,   // [2:0] command
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] tone_on, [12:1] tone_frequency,
                                      // [21:13] song_position, [22] playing,
                                      // [23] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int unsigned AW = $clog2(SONG_DEPTH);
  localparam int unsigned PW = $clog2(SONG_DEPTH + 1);
  localparam logic [PW-1:0] POS_END = PW'(SONG_DEPTH);
  localparam logic [tdns_pkg::NOTE_W-1:0] NOTE_LIMIT = tdns_pkg::NOTE_W'(NOTE_TABLE_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // configuration
  logic                          loop_enable;
  logic [tdns_pkg::STEP_W-1:0]   tick_step_ms;

  // playback state
  logic [PW-1:0]                 position, position_next;
  logic signed [tdns_pkg::NOTE_W-1:0] last_note, last_note_next;
  logic [tdns_pkg::ELAPS_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic                          play_flag, play_flag_next;
  logic                          spk_en, spk_en_next;
  logic [tdns_pkg::FREQ_W-1:0]   spk_freq, spk_freq_next;

  // captured command and end-of-memory flags for the read in flight
  tdns_pkg::cmd_t                cmd_q;
  logic                          cur_end_q;
  logic                          nxt_end_q;

  tdns_pkg::song_entry_t         rd_cur, rd_nxt, wr_entry;
  logic                          accept, commit, is_load, is_tick;
  logic [PW-1:0]                 pos_inc;
  logic [tdns_pkg::NOTE_W-1:0]   entry_index;
  logic [tdns_pkg::FREQ_W-1:0]   hz;
  logic signed [tdns_pkg::NOTE_W-1:0] cur_note;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign commit    = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign entry_index       = s_tdata[7:0];
  assign wr_entry.note     = s_tdata[15:8];
  assign wr_entry.duration = s_tdata[31:16];
  assign is_load = accept && (s_tuser == tdns_pkg::CMD_LOAD) &&
                   (32'(entry_index) < SONG_DEPTH);
  assign is_tick = accept && (s_tuser == tdns_pkg::CMD_TICK);
  assign pos_inc = position + 1'b1;

  tdns_song_mem #(
    .SONG_DEPTH (SONG_DEPTH)
  ) u_mem (
    .clk         (clk),
    .wr_en       (is_load),
    .wr_addr     (AW'(entry_index)),
    .wr_data     (wr_entry),
    .rd_en       (is_tick),
    .rd_addr_cur (position[AW-1:0]),
    .rd_addr_nxt (pos_inc[AW-1:0]),
    .rd_cur      (rd_cur),
    .rd_nxt      (rd_nxt)
  );

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable  <= 1'b0;
      tick_step_ms <= tdns_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tdns_pkg::cfg_reg_t'(cfg_index))
        tdns_pkg::REG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        tdns_pkg::REG_TICK_STEP_MS: tick_step_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture command; end flags settle whether memory data is meaningful
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= tdns_pkg::cmd_t'(s_tuser);
      cur_end_q <= (position == POS_END);
      nxt_end_q <= (pos_inc == POS_END);
    end
  end

  assign cur_note = rd_cur.note;
  // notes at or above the table size are silent
  assign hz = ($signed({cur_note[tdns_pkg::NOTE_W-1], cur_note}) >=
               $signed({1'b0, NOTE_LIMIT}))
              ? '0 : tdns_pkg::note_hz(cur_note[6:0]);

  always_comb begin
    state_next     = state;
    position_next  = position;
    last_note_next = last_note;
    elapsed_ms_next = elapsed_ms;
    play_flag_next = play_flag;
    spk_en_next    = spk_en;
    spk_freq_next  = spk_freq;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_next = ST_IDLE;
          unique case (cmd_q)
            tdns_pkg::CMD_TICK: begin
              if (!play_flag) begin
                spk_en_next   = 1'b0;
                spk_freq_next = '0;
              end else if (cur_end_q || cur_note < 0) begin
                // end marker: silence, optionally rewind
                spk_en_next   = 1'b0;
                spk_freq_next = '0;
                if (loop_enable) begin
                  position_next   = '0;
                  last_note_next  = '0;
                  elapsed_ms_next = '0;
                end
              end else begin
                if (cur_note > 0) begin
                  if (cur_note != last_note) begin
                    spk_freq_next  = hz;
                    spk_en_next    = (hz != '0);
                    last_note_next = cur_note;
                  end
                end else begin
                  spk_en_next    = 1'b0;
                  spk_freq_next  = '0;
                  last_note_next = '0;
                end
                if (elapsed_ms >= {1'b0, rd_cur.duration}) begin
                  position_next   = pos_inc;
                  elapsed_ms_next = '0;
                  // repeated note is cut so it sounds anew
                  if (!nxt_end_q && (rd_nxt.note == last_note_next)) begin
                    spk_en_next    = 1'b0;
                    spk_freq_next  = '0;
                    last_note_next = '0;
                  end
                end else begin
                  elapsed_ms_next = elapsed_ms + tdns_pkg::ELAPS_W'(tick_step_ms);
                end
              end
            end
            tdns_pkg::CMD_LOAD: ;
            tdns_pkg::CMD_PLAY: begin
              position_next   = '0;
              last_note_next  = '0;
              elapsed_ms_next = '0;
              play_flag_next  = 1'b1;
            end
            tdns_pkg::CMD_STOP: begin
              spk_en_next     = 1'b0;
              spk_freq_next   = '0;
              play_flag_next  = 1'b0;
              position_next   = '0;
              last_note_next  = '0;
              elapsed_ms_next = '0;
            end
            tdns_pkg::CMD_PAUSE: begin
              spk_en_next    = 1'b0;
              spk_freq_next  = '0;
              play_flag_next = 1'b0;
            end
            tdns_pkg::CMD_RESUME: begin
              play_flag_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      position   <= '0;
      last_note  <= '0;
      elapsed_ms <= '0;
      play_flag  <= 1'b0;
      spk_en     <= 1'b0;
      spk_freq   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      position   <= position_next;
      last_note  <= last_note_next;
      elapsed_ms <= elapsed_ms_next;
      play_flag  <= play_flag_next;
      spk_en     <= spk_en_next;
      spk_freq   <= spk_freq_next;
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // state only moves on commit, so it doubles as the result register
  assign m_tdata = {1'b0, play_flag, tdns_pkg::POS_OUT_W'(position), spk_freq, spk_en};

endmodule

`default_nettype wire
